@@ rtl/bsme_pkg.sv @@
// Package for the byte stack machine executor.
// Holds action codes, status codes, arithmetic op codes and the sequencer states.
// No dependencies.
package bsme_pkg;

  localparam int unsigned STACK_BYTES_DEF = 4096;

  localparam logic [4:0] ACT_END     = 5'd0;
  localparam logic [4:0] ACT_ERROR   = 5'd1;
  localparam logic [4:0] ACT_ALLOC   = 5'd2;
  localparam logic [4:0] ACT_DEALLOC = 5'd3;
  localparam logic [4:0] ACT_SET     = 5'd4;
  localparam logic [4:0] ACT_COPY    = 5'd5;
  localparam logic [4:0] ACT_ADD16   = 5'd7;
  localparam logic [4:0] ACT_SUB16   = 5'd8;
  localparam logic [4:0] ACT_MUL16   = 5'd9;
  localparam logic [4:0] ACT_DIV16   = 5'd10;
  localparam logic [4:0] ACT_MOD16   = 5'd11;
  localparam logic [4:0] ACT_ADD32   = 5'd12;
  localparam logic [4:0] ACT_SUB32   = 5'd13;
  localparam logic [4:0] ACT_MUL32   = 5'd14;
  localparam logic [4:0] ACT_DIV32   = 5'd15;
  localparam logic [4:0] ACT_MOD32   = 5'd16;

  localparam logic [2:0] ST_CONTINUE = 3'd0;
  localparam logic [2:0] ST_ENDED    = 3'd1;
  localparam logic [2:0] ST_ERROR    = 3'd2;
  localparam logic [2:0] ST_FAULT    = 3'd3;
  localparam logic [2:0] ST_DIVZERO  = 3'd4;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_FILL,
    S_CP_RD,
    S_CP_WR,
    S_LD_RD,
    S_LD_CAP,
    S_EXEC,
    S_DIV,
    S_DFIN,
    S_WB,
    S_DONE
  } seq_state_t;

endpackage

@@ rtl/byte_stack_machine_executor.sv @@
// Byte stack machine executor: one bytecode instruction per input transaction.
// Depends on bsme_pkg. The stack lives in a single byte-wide synchronous memory.
// An instruction runs check, per-byte fill, copy read/write or operand load read/capture steps,
//   the arithmetic step, restoring divide steps and a final one for div or mod, per-byte write-back
//   and done, before the next is taken; a result still waiting in the output register stalls this.
// Reset: rst_n synchronous, active low, empties the stack; the memory is not cleared.
module byte_stack_machine_executor
  import bsme_pkg::*;
#(
  parameter int unsigned STACK_BYTES = STACK_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // first_param[15:0], second_param[31:16], third_param[47:32]
  input  logic [4:0]  in_tuser,   // action[4:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // error_code[15:0], stack_used[28:16],
                                  // written_value[60:29], zero fill[63:61]
  output logic [2:0]  out_tuser   // status[2:0]
);

  localparam int AW = $clog2(STACK_BYTES);
  localparam int UW = $clog2(STACK_BYTES + 1);

  // Stack memory: one write and one registered read port.
  logic [7:0]    mem [STACK_BYTES];
  logic [7:0]    rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  seq_state_t state_r, state_nxt;
  logic [4:0]    act_r, act_nxt;
  logic [15:0]   p1_r, p1_nxt, p2_r, p2_nxt, p3_r, p3_nxt;
  logic [UW-1:0] used_r, used_nxt;
  logic [2:0]    status_r, status_nxt;
  logic [15:0]   ecode_r, ecode_nxt;
  logic [31:0]   wval_r, wval_nxt;
  logic [15:0]   off_r, off_nxt, len_r, len_nxt;
  logic [AW-1:0] pos_d_r, pos_d_nxt, pos_a_r, pos_a_nxt, pos_b_r, pos_b_nxt;
  logic          desc_r, desc_nxt;
  logic [31:0]   a_r, a_nxt, b_r, b_nxt, r_r, r_nxt;
  logic          neg_a_r, neg_a_nxt, neg_b_r, neg_b_nxt;
  logic [32:0]   rem_r, rem_nxt;
  logic [31:0]   quo_r, quo_nxt, dvs_r, dvs_nxt;
  logic [5:0]    dcnt_r, dcnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [2:0]    out_status_r, out_status_nxt;
  logic [15:0]   out_ecode_r, out_ecode_nxt;
  logic [12:0]   out_used_r, out_used_nxt;
  logic [31:0]   out_wval_r, out_wval_nxt;

  // Decode of the held instruction.
  logic        w16;
  logic [2:0]  sz;
  logic [2:0]  op_sel;
  logic [31:0] mask;
  logic [17:0] used18;
  logic [15:0] idx;
  logic [15:0] ld_k;
  logic [32:0] trial;

  always_comb begin
    w16    = (act_r <= ACT_MOD16);
    sz     = w16 ? 3'd2 : 3'd4;
    op_sel = w16 ? 3'(act_r - ACT_ADD16) : 3'(act_r - ACT_ADD32);
    mask   = w16 ? 32'h0000_FFFF : 32'hFFFF_FFFF;
    used18 = 18'(used_r);
    idx    = desc_r ? (len_r - 16'd1 - off_r) : off_r;
    ld_k   = off_r - 16'(sz);
    trial  = {rem_r[31:0], quo_r[31]} - {1'b0, dvs_r};
  end

  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    p1_nxt         = p1_r;
    p2_nxt         = p2_r;
    p3_nxt         = p3_r;
    used_nxt       = used_r;
    status_nxt     = status_r;
    ecode_nxt      = ecode_r;
    wval_nxt       = wval_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    pos_d_nxt      = pos_d_r;
    pos_a_nxt      = pos_a_r;
    pos_b_nxt      = pos_b_r;
    desc_nxt       = desc_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    r_nxt          = r_r;
    neg_a_nxt      = neg_a_r;
    neg_b_nxt      = neg_b_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    dvs_nxt        = dvs_r;
    dcnt_nxt       = dcnt_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_ecode_nxt  = out_ecode_r;
    out_used_nxt   = out_used_r;
    out_wval_nxt   = out_wval_r;
    mem_we         = 1'b0;
    mem_wa         = '0;
    mem_wd         = '0;
    mem_ra         = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          act_nxt    = in_tuser;
          p1_nxt     = in_tdata[15:0];
          p2_nxt     = in_tdata[31:16];
          p3_nxt     = in_tdata[47:32];
          status_nxt = ST_CONTINUE;
          ecode_nxt  = '0;
          wval_nxt   = '0;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        off_nxt   = '0;
        case (act_r)
          ACT_END: status_nxt = ST_ENDED;
          ACT_ERROR: begin
            status_nxt = ST_ERROR;
            ecode_nxt  = p1_r;
          end
          ACT_ALLOC: begin
            if (used18 + 18'(p1_r) > 18'(STACK_BYTES)) begin
              status_nxt = ST_FAULT;
            end else if (p1_r != 16'd0) begin
              len_nxt   = p1_r;
              state_nxt = S_FILL;
            end
          end
          ACT_DEALLOC: begin
            if (18'(p1_r) > used18) begin
              status_nxt = ST_FAULT;
            end else begin
              used_nxt = UW'(used18 - 18'(p1_r));
            end
          end
          ACT_SET: begin
            if (18'(p1_r) + 18'd1 > used18) begin
              status_nxt = ST_FAULT;
            end else begin
              mem_we = 1'b1;
              mem_wa = AW'(used18 - 18'(p1_r) - 18'd1);
              mem_wd = p2_r[7:0];
            end
          end
          ACT_COPY: begin
            if ((18'(p1_r) + 18'(p3_r) > used18) || (18'(p2_r) + 18'(p3_r) > used18)) begin
              status_nxt = ST_FAULT;
            end else if (p3_r != 16'd0) begin
              pos_d_nxt = AW'(used18 - 18'(p1_r) - 18'(p3_r));
              pos_a_nxt = AW'(used18 - 18'(p2_r) - 18'(p3_r));
              // Moving toward higher addresses walks from the top end down.
              desc_nxt  = (p1_r < p2_r);
              len_nxt   = p3_r;
              state_nxt = S_CP_RD;
            end
          end
          ACT_ADD16, ACT_SUB16, ACT_MUL16, ACT_DIV16, ACT_MOD16,
          ACT_ADD32, ACT_SUB32, ACT_MUL32, ACT_DIV32, ACT_MOD32: begin
            if ((18'(p1_r) + 18'(sz) > used18) || (18'(p2_r) + 18'(sz) > used18) ||
                (18'(p3_r) + 18'(sz) > used18)) begin
              status_nxt = ST_FAULT;
            end else begin
              pos_d_nxt = AW'(used18 - 18'(p1_r) - 18'(sz));
              pos_a_nxt = AW'(used18 - 18'(p2_r) - 18'(sz));
              pos_b_nxt = AW'(used18 - 18'(p3_r) - 18'(sz));
              len_nxt   = {12'd0, sz, 1'b0};
              a_nxt     = '0;
              b_nxt     = '0;
              state_nxt = S_LD_RD;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FILL: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(used18 + 18'(off_r));
        mem_wd  = p2_r[7:0];
        off_nxt = off_r + 16'd1;
        if (off_r == len_r - 16'd1) begin
          used_nxt  = UW'(used18 + 18'(len_r));
          state_nxt = S_DONE;
        end
      end
      S_CP_RD: begin
        mem_ra    = AW'(18'(pos_a_r) + 18'(idx));
        state_nxt = S_CP_WR;
      end
      S_CP_WR: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(18'(pos_d_r) + 18'(idx));
        mem_wd  = rdata_r;
        off_nxt = off_r + 16'd1;
        state_nxt = (off_r == len_r - 16'd1) ? S_DONE : S_CP_RD;
      end
      S_LD_RD: begin
        if (off_r < 16'(sz)) begin
          mem_ra = AW'(18'(pos_a_r) + 18'(off_r));
        end else begin
          mem_ra = AW'(18'(pos_b_r) + 18'(ld_k));
        end
        state_nxt = S_LD_CAP;
      end
      S_LD_CAP: begin
        if (off_r < 16'(sz)) begin
          a_nxt[{off_r[1:0], 3'b000} +: 8] = rdata_r;
        end else begin
          b_nxt[{ld_k[1:0], 3'b000} +: 8] = rdata_r;
        end
        off_nxt   = off_r + 16'd1;
        state_nxt = (off_r == len_r - 16'd1) ? S_EXEC : S_LD_RD;
      end
      S_EXEC: begin
        off_nxt   = '0;
        state_nxt = S_WB;
        case (op_sel)
          OP_ADD: r_nxt = (a_r + b_r) & mask;
          OP_SUB: r_nxt = (a_r - b_r) & mask;
          OP_MUL: r_nxt = (a_r * b_r) & mask;
          default: begin
            if (b_r == 32'd0) begin
              status_nxt = ST_DIVZERO;
              state_nxt  = S_DONE;
            end else begin
              neg_a_nxt = w16 ? a_r[15] : a_r[31];
              neg_b_nxt = w16 ? b_r[15] : b_r[31];
              quo_nxt   = (w16 ? a_r[15] : a_r[31]) ? ((32'd0 - a_r) & mask) : a_r;
              dvs_nxt   = (w16 ? b_r[15] : b_r[31]) ? ((32'd0 - b_r) & mask) : b_r;
              rem_nxt   = '0;
              dcnt_nxt  = '0;
              state_nxt = S_DIV;
            end
          end
        endcase
      end
      S_DIV: begin
        // One restoring step per cycle; the dividend shifts out of quo_r.
        if (!trial[32]) begin
          rem_nxt = trial;
          quo_nxt = {quo_r[30:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[31:0], quo_r[31]};
          quo_nxt = {quo_r[30:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'd31) begin
          state_nxt = S_DFIN;
        end
      end
      S_DFIN: begin
        if (op_sel == OP_DIV) begin
          r_nxt = ((neg_a_r != neg_b_r) ? (32'd0 - quo_r) : quo_r) & mask;
        end else begin
          r_nxt = (neg_a_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0]) & mask;
        end
        state_nxt = S_WB;
      end
      S_WB: begin
        mem_we  = 1'b1;
        mem_wa  = AW'(18'(pos_d_r) + 18'(off_r));
        mem_wd  = r_r[{off_r[1:0], 3'b000} +: 8];
        off_nxt = off_r + 16'd1;
        if (off_r == 16'(sz) - 16'd1) begin
          wval_nxt  = w16 ? {{16{r_r[15]}}, r_r[15:0]} : r_r;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // The result register is free or being emptied this cycle.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_ecode_nxt  = ecode_r;
          out_wval_nxt   = wval_r;
          if (status_r != ST_CONTINUE) begin
            used_nxt     = '0;
            out_used_nxt = '0;
          end else begin
            out_used_nxt = 13'(used_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    p1_r         <= p1_nxt;
    p2_r         <= p2_nxt;
    p3_r         <= p3_nxt;
    status_r     <= status_nxt;
    ecode_r      <= ecode_nxt;
    wval_r       <= wval_nxt;
    off_r        <= off_nxt;
    len_r        <= len_nxt;
    pos_d_r      <= pos_d_nxt;
    pos_a_r      <= pos_a_nxt;
    pos_b_r      <= pos_b_nxt;
    desc_r       <= desc_nxt;
    a_r          <= a_nxt;
    b_r          <= b_nxt;
    r_r          <= r_nxt;
    neg_a_r      <= neg_a_nxt;
    neg_b_r      <= neg_b_nxt;
    rem_r        <= rem_nxt;
    quo_r        <= quo_nxt;
    dvs_r        <= dvs_nxt;
    dcnt_r       <= dcnt_nxt;
    out_status_r <= out_status_nxt;
    out_ecode_r  <= out_ecode_nxt;
    out_used_r   <= out_used_nxt;
    out_wval_r   <= out_wval_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {3'b000, out_wval_r, out_used_r, out_ecode_r};

endmodule

@@ rtl/bsme_checker.sv @@
// Port-level checker for the byte stack machine executor, with its bind.
// Depends on bsme_pkg and on the top level's ports.
module bsme_checker
  import bsme_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [2:0]  out_tuser
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result dropped while stalled");

  // Every terminating status leaves an empty stack.
  a_term_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_CONTINUE) |-> (out_tdata[28:16] == 13'd0))
    else $error("stack not emptied on termination");

  // Only an error instruction carries an error code.
  a_ecode: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[15:0] != 16'd0) |-> (out_tuser == ST_ERROR))
    else $error("error code without error status");

  // A written value only comes with a continuing status.
  a_wval: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[60:29] != 32'd0) |-> (out_tuser == ST_CONTINUE))
    else $error("written value on a terminating instruction");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind byte_stack_machine_executor bsme_checker u_bsme_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ dv/byte_stack_machine_executor_tb.sv @@
// Self-checking testbench for byte_stack_machine_executor: a directed table of instructions,
// then random instruction programs, checked against a behavioral stack machine in the bench.
// Depends on bsme_pkg and the RTL top level.
`timescale 1ns / 1ps

module byte_stack_machine_executor_tb;
  import bsme_pkg::*;

  localparam int unsigned STACK_SIZE = STACK_BYTES_DEF;
  localparam int unsigned IDLE_PCT = 13;
  localparam int unsigned WATCHDOG_LIMIT = 200000;
  localparam int unsigned RANDOM_ITEMS = 700;

  // One instruction, and the result it gives.
  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
  } instr_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] error_code;
    logic [12:0] stack_used;
    logic [31:0] written_value;
  } outcome_t;

  // A directed row: the instruction, plus an outcome typed in when has_fixed is set.
  typedef struct {
    instr_t   ins;
    bit       has_fixed;
    outcome_t fixed;
  } vector_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [4:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [2:0]  out_tuser;

  byte_stack_machine_executor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Bench copy of the stack.
  logic [7:0]  stack_mem [STACK_SIZE];
  int unsigned stack_depth;
  outcome_t    pending_results[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          stim_done;
  bit          calm_receiver;  // no random stalls on the result side
  bit          calm_sender;

  // Computes the outcome of one instruction and updates the bench stack.
  function automatic outcome_t execute_instr(instr_t ins);
    outcome_t    res;
    int unsigned size;
    int unsigned op;
    int unsigned d1;
    int unsigned d2;
    int unsigned d3;
    logic [7:0]  tmp [];
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] mask;
    logic [31:0] sbit;
    bit          na;
    bit          nb;
    res = '{ST_CONTINUE, 16'd0, 13'd0, 32'd0};
    d1 = ins.p1;
    d2 = ins.p2;
    d3 = ins.p3;
    case (ins.action)
      ACT_END: begin
        res.status = ST_ENDED;
      end
      ACT_ERROR: begin
        res.status = ST_ERROR;
        res.error_code = ins.p1;
      end
      ACT_ALLOC: begin
        if (stack_depth + d1 > STACK_SIZE) begin
          res.status = ST_FAULT;
        end else begin
          for (int i = 0; i < d1; i++) stack_mem[stack_depth + i] = ins.p2[7:0];
          stack_depth += d1;
        end
      end
      ACT_DEALLOC: begin
        if (d1 > stack_depth) res.status = ST_FAULT;
        else stack_depth -= d1;
      end
      ACT_SET: begin
        if (d1 + 1 > stack_depth) res.status = ST_FAULT;
        else stack_mem[stack_depth - d1 - 1] = ins.p2[7:0];
      end
      ACT_COPY: begin
        if (d1 + d3 > stack_depth || d2 + d3 > stack_depth) begin
          res.status = ST_FAULT;
        end else if (d3 != 0) begin
          // The whole source is read before anything is written, so overlap is harmless.
          tmp = new[d3];
          for (int i = 0; i < d3; i++) tmp[i] = stack_mem[stack_depth - d2 - d3 + i];
          for (int i = 0; i < d3; i++) stack_mem[stack_depth - d1 - d3 + i] = tmp[i];
        end
      end
      default: begin
        if (ins.action >= ACT_ADD16 && ins.action <= ACT_MOD32) begin
          size = (ins.action <= ACT_MOD16) ? 2 : 4;
          op = (ins.action <= ACT_MOD16) ? ins.action - ACT_ADD16 : ins.action - ACT_ADD32;
          mask = (size == 2) ? 32'h0000_FFFF : 32'hFFFF_FFFF;
          sbit = (size == 2) ? 32'h0000_8000 : 32'h8000_0000;
          if (d1 + size > stack_depth || d2 + size > stack_depth
              || d3 + size > stack_depth) begin
            res.status = ST_FAULT;
          end else begin
            a = 0;
            b = 0;
            for (int i = 0; i < size; i++) begin
              a |= 32'(stack_mem[stack_depth - d2 - size + i]) << (8 * i);
              b |= 32'(stack_mem[stack_depth - d3 - size + i]) << (8 * i);
            end
            r = 0;
            if (op == OP_ADD) r = a + b;
            else if (op == OP_SUB) r = a - b;
            else if (op == OP_MUL) r = a * b;
            else if (b == 0) res.status = ST_DIVZERO;
            else begin
              na = (a & sbit) != 0;
              nb = (b & sbit) != 0;
              ma = na ? ((32'd0 - a) & mask) : a;
              mb = nb ? ((32'd0 - b) & mask) : b;
              if (op == OP_DIV) begin
                r = ma / mb;
                if (na != nb) r = 32'd0 - r;
              end else begin
                r = ma % mb;
                if (na) r = 32'd0 - r;
              end
            end
            if (res.status == ST_CONTINUE) begin
              r &= mask;
              for (int i = 0; i < size; i++)
                stack_mem[stack_depth - d1 - size + i] = r[8*i +: 8];
              res.written_value = (size == 2 && r[15]) ? (r | 32'hFFFF_0000) : r;
            end
          end
        end
        // Debug and undefined actions change nothing.
      end
    endcase
    // Any terminating status empties the stack.
    if (res.status != ST_CONTINUE) stack_depth = 0;
    res.stack_used = stack_depth[12:0];
    return res;
  endfunction

  // Offers one instruction and waits for the transaction. The valid stays high across
  // back-to-back items and is only lowered by a random idle, the drain or at the end.
  task automatic send_instr(instr_t ins);
    while (!calm_sender && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= ins.action;
    in_tdata  <= {ins.p3, ins.p2, ins.p1};
    do @(posedge clk); while (!in_tready);
  endtask

  // Runs one instruction: predicts or takes the typed outcome, then drives it.
  task automatic issue(instr_t ins, bit has_fixed, outcome_t fixed);
    outcome_t predicted;
    predicted = execute_instr(ins);
    if (has_fixed && predicted != fixed) begin
      $display("%0t: directed row for action %0d expected %h predicted %h",
               $time, ins.action, fixed, predicted);
      error_count++;
    end
    pending_results.push_back(has_fixed ? fixed : predicted);
    send_instr(ins);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Random operand distance, mostly inside the used area, sometimes just outside.
  function automatic logic [15:0] rand_dist(int unsigned size);
    int unsigned lim;
    lim = (stack_depth >= size) ? stack_depth - size : 0;
    case ($urandom_range(19))
      0:       return 16'($urandom());
      1:       return 16'(lim + 1);
      default: return 16'($urandom_range(lim, 0));
    endcase
  endfunction

  // Builds a random instruction that usually keeps the program alive.
  function automatic instr_t rand_instr();
    instr_t ins;
    int unsigned pick;
    int unsigned len;
    ins.p1 = 16'($urandom());
    ins.p2 = 16'($urandom());
    ins.p3 = 16'($urandom());
    pick = $urandom_range(99);
    if (stack_depth < 8 && pick < 70) pick = 0;
    if (pick < 18) begin
      ins.action = ACT_ALLOC;
      ins.p1 = ($urandom_range(49) == 0) ? 16'($urandom()) : 16'($urandom_range(12, 0));
    end else if (pick < 26) begin
      ins.action = ACT_DEALLOC;
      ins.p1 = ($urandom_range(19) == 0) ? 16'(stack_depth + 1)
                                          : 16'($urandom_range(stack_depth / 2, 0));
    end else if (pick < 36) begin
      ins.action = ACT_SET;
      ins.p1 = rand_dist(1);
    end else if (pick < 44) begin
      ins.action = ACT_COPY;
      len = $urandom_range((stack_depth < 8) ? stack_depth : 8, 0);
      ins.p3 = 16'(len);
      ins.p1 = rand_dist(len);
      ins.p2 = rand_dist(len);
    end else if (pick < 94) begin
      ins.action = 5'($urandom_range(ACT_MOD32, ACT_ADD16));
      len = (ins.action <= ACT_MOD16) ? 2 : 4;
      ins.p1 = rand_dist(len);
      ins.p2 = rand_dist(len);
      ins.p3 = rand_dist(len);
    end else if (pick < 97) begin
      ins.action = 5'($urandom_range(31, 17));
      if ($urandom_range(1)) ins.action = 5'd6;
    end else begin
      ins.action = 5'($urandom_range(1, 0));
    end
    return ins;
  endfunction

  // Directed table: extremes, every action and each named corner case.
  localparam outcome_t NO_FIX = '{ST_CONTINUE, 16'd0, 13'd0, 32'd0};
  vector_t directed[] = '{
    // Dealloc on an empty stack underflows.
    '{'{ACT_DEALLOC, 16'd1, 16'd0, 16'd0}, 1'b1, '{ST_FAULT, 16'd0, 13'd0, 32'd0}},
    // Largest alloc overflows.
    '{'{ACT_ALLOC, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{ST_FAULT, 16'd0, 13'd0, 32'd0}},
    // Fill the whole stack exactly, then one more byte overflows.
    '{'{ACT_ALLOC, 16'd4096, 16'h00A5, 16'd0}, 1'b1, '{ST_CONTINUE, 16'd0, 13'd4096, 32'd0}},
    '{'{ACT_ALLOC, 16'd1, 16'd0, 16'd0}, 1'b1, '{ST_FAULT, 16'd0, 13'd0, 32'd0}},
    '{'{ACT_ERROR, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{ST_ERROR, 16'hFFFF, 13'd0, 32'd0}},
    '{'{ACT_END, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{ST_ENDED, 16'd0, 13'd0, 32'd0}},
    '{'{ACT_ALLOC, 16'd16, 16'hFF00, 16'd0}, 1'b0, NO_FIX},
    // 16-bit most negative divided by minus one.
    '{'{ACT_SET, 16'd0, 16'h0080, 16'd0}, 1'b0, NO_FIX},
    '{'{ACT_SET, 16'd2, 16'h00FF, 16'd0}, 1'b0, NO_FIX},
    '{'{ACT_SET, 16'd3, 16'h00FF, 16'd0}, 1'b0, NO_FIX},
    '{'{ACT_DIV16, 16'd4, 16'd0, 16'd2}, 1'b0, NO_FIX},
    '{'{ACT_MOD16, 16'd6, 16'd0, 16'd2}, 1'b0, NO_FIX},
    '{'{ACT_ADD16, 16'd8, 16'd0, 16'd2}, 1'b0, NO_FIX},
    '{'{ACT_SUB16, 16'd8, 16'd0, 16'd2}, 1'b0, NO_FIX},
    '{'{ACT_MUL16, 16'd8, 16'd2, 16'd0}, 1'b0, NO_FIX},
    '{'{ACT_ADD32, 16'd12, 16'd0, 16'd4}, 1'b0, NO_FIX},
    '{'{ACT_SUB32, 16'd12, 16'd0, 16'd4}, 1'b0, NO_FIX},
    '{'{ACT_MUL32, 16'd12, 16'd4, 16'd8}, 1'b0, NO_FIX},
    '{'{ACT_DIV32, 16'd12, 16'd4, 16'd0}, 1'b0, NO_FIX},
    '{'{ACT_MOD32, 16'd12, 16'd4, 16'd8}, 1'b0, NO_FIX},
    // Overlapping copy and a zero-length copy at the bottom of the area.
    '{'{ACT_COPY, 16'd0, 16'd3, 16'd6}, 1'b0, NO_FIX},
    '{'{ACT_COPY, 16'd16, 16'd16, 16'd0}, 1'b0, NO_FIX},
    '{'{5'd6, 16'd0, 16'd0, 16'd0}, 1'b0, NO_FIX},
    '{'{5'd31, 16'd0, 16'd0, 16'd0}, 1'b0, NO_FIX},
    // Out-of-area operand on a set.
    '{'{ACT_SET, 16'd16, 16'd0, 16'd0}, 1'b1, '{ST_FAULT, 16'd0, 13'd0, 32'd0}}
  };

  // Stimulus process.
  initial begin
    instr_t ins;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    stack_depth = 0;
    error_count = 0;
    stim_done = 1'b0;
    calm_sender = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) issue(directed[k].ins, directed[k].has_fixed, directed[k].fixed);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A stretch with no idling on the sending side.
      calm_sender = (n >= 200 && n < 300);
      // Once, the sender waits for every outstanding result to come back.
      if (n == 400) drain_results();
      ins = rand_instr();
      // Occasionally take the divisor from the top of the stack.
      if (ins.action inside {ACT_DIV16, ACT_MOD16, ACT_DIV32, ACT_MOD32}
          && $urandom_range(9) == 0 && stack_depth >= 4) ins.p3 = 16'd0;
      issue(ins, 1'b0, NO_FIX);
    end
    in_tvalid <= 1'b0;
    stim_done = 1'b1;
  end

  // The long hold-off happens once, during the random part.
  int unsigned hold_fired = 0;
  function automatic bit idle_count_ok();
    if (hold_fired == 0 && $time > 250000) begin
      hold_fired = 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Result side: random stalls, one long hold-off and one calm stretch.
  initial begin
    out_tready = 1'b0;
    calm_receiver = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (idle_count_ok()) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      calm_receiver = ($time > 100000 && $time < 200000);
      out_tready <= calm_receiver || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Checker: each result transaction against the oldest prediction.
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.status        = out_tuser;
      got.error_code    = out_tdata[15:0];
      got.stack_used    = out_tdata[28:16];
      got.written_value = out_tdata[60:29];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d", $time, got.status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          error_count++;
        end
        if (got.error_code !== want.error_code) begin
          $display("%0t: error_code expected %h actual %h", $time,
                   want.error_code, got.error_code);
          error_count++;
        end
        if (got.stack_used !== want.stack_used) begin
          $display("%0t: stack_used expected %0d actual %0d", $time,
                   want.stack_used, got.stack_used);
          error_count++;
        end
        if (got.written_value !== want.written_value) begin
          $display("%0t: written_value expected %h actual %h", $time,
                   want.written_value, got.written_value);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side, plus the end of the run.
  initial begin
    idle_cycles = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (stim_done && pending_results.size() == 0) begin
        // Let any trailing activity settle.
        repeat (200) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0) begin
          $display("CHECK OK");
        end else begin
          $display("CHECK FAILED");
        end
        $finish;
      end
    end
  end

endmodule

@@ files.f @@
rtl/bsme_pkg.sv
rtl/byte_stack_machine_executor.sv
rtl/bsme_checker.sv
dv/byte_stack_machine_executor_tb.sv
